FILE: rtl/rctm_pkg.sv
// Package for the raycast column texel mapper: constants, codes, cell types.
// No dependencies.
`default_nettype none
package rctm_pkg;
    localparam int SCREEN_ROWS_DEF = 1024;
    localparam int MAX_TEX_DIM_DEF = 1024;
    localparam int QW  = 27;   // dividend width: (pos-mid) * h
    localparam int LHW = 16;   // divisor width
    localparam int DIV_STEPS = QW;

    localparam logic [1:0] KIND_CEIL  = 2'd0;
    localparam logic [1:0] KIND_WALL  = 2'd1;
    localparam logic [1:0] KIND_FLOOR = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam logic [1:0] REG_TEX_W   = 2'd0;
    localparam logic [1:0] REG_TEX_H   = 2'd1;
    localparam logic [1:0] REG_CEIL_C  = 2'd2;
    localparam logic [1:0] REG_FLOOR_C = 2'd3;

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_OUT} state_t;

    // word passed from one divider cell to the next
    typedef struct packed {
        logic          vld;
        logic [QW-1:0] num;   // remaining dividend bits, MSB first
        logic [LHW:0]  rem;   // partial remainder
        logic [QW-1:0] quo;   // quotient bits so far
    } div_word_t;
endpackage
`default_nettype wire

FILE: rtl/rctm_if.sv
// Valid/ready channel interface carrying generic payload.
// Depends on nothing.
`default_nettype none
interface rctm_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/rctm_div_cell.sv
// One restoring-division cell: one quotient bit per word handed on.
// Depends on rctm_pkg.
`default_nettype none
module rctm_div_cell
    import rctm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic [LHW-1:0] divisor,
    input  wire div_word_t din,
    output div_word_t      dout
);
    div_word_t     word_next;
    logic [LHW:0]  trial;
    logic [LHW+1:0] diff;

    // shift in next dividend bit, subtract when it fits
    always_comb
    begin
        trial = {din.rem[LHW-1:0], din.num[QW-1]};
        diff  = {1'b0, trial} - {2'b0, divisor};
        word_next.vld = din.vld;
        word_next.num = {din.num[QW-2:0], 1'b0};
        if (!diff[LHW+1])
        begin
            word_next.rem = diff[LHW:0];
            word_next.quo = {din.quo[QW-2:0], 1'b1};
        end
        else
        begin
            word_next.rem = trial;
            word_next.quo = {din.quo[QW-2:0], 1'b0};
        end
    end

    // hand the word to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dout <= '0;
        else
            dout <= word_next;
    end
endmodule
`default_nettype wire

FILE: rtl/rctm_div_chain.sv
// Row of division cells computing dividend / divisor, one bit per cell.
// Depends on rctm_pkg, rctm_div_cell.
`default_nettype none
module rctm_div_chain
    import rctm_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [QW-1:0]  dividend,
    input  wire logic [LHW-1:0] divisor,
    output logic                done,
    output logic [QW-1:0]       quotient
);
    div_word_t link [DIV_STEPS+1];

    always_comb
    begin
        link[0].vld = start;
        link[0].num = dividend;
        link[0].rem = '0;
        link[0].quo = '0;
    end

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_cell
        rctm_div_cell u_cell (
            .clk(clk), .rst_n(rst_n), .divisor(divisor),
            .din(link[i]), .dout(link[i+1])
        );
    end

    assign done     = link[DIV_STEPS].vld;
    assign quotient = link[DIV_STEPS].quo;
endmodule
`default_nettype wire

FILE: rtl/raycast_column_texel_mapper_core.sv
// Raycast column texel mapper top level; depends on rctm_pkg, rctm_if, rctm_div_chain.
// Load words give no result; the next word may follow at once.
// Wall rows: accept registers the row, ST_DIV starts the 27 divider cells, and the
// output register takes the quotient when it leaves the last cell. Other rows: ST_DIV
// loads the output register. One word at a time; output stalls hold the input.
// rst_n async active low: all but row/result data registers reset; no result pending.
`default_nettype none
module raycast_column_texel_mapper_core
    import rctm_pkg::*;
#(
    parameter int SCREEN_ROWS = SCREEN_ROWS_DEF,
    parameter int MAX_TEX_DIM = MAX_TEX_DIM_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    rctm_if.sink       in_ch,
    rctm_if.source     out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int MID = SCREEN_ROWS / 2;

    // input unpack: op side dxp dyp frac lh top bot col row
    logic        i_op, i_side, i_xp, i_yp;
    logic [15:0] i_frac, i_lh;
    logic [9:0]  i_top, i_bot, i_row;
    logic [11:0] i_col;
    assign {i_op, i_side, i_xp, i_yp, i_frac, i_lh, i_top, i_bot, i_col, i_row} =
        in_ch.data;

    // configuration
    logic [10:0] tex_w_reg, tex_h_reg;
    logic [23:0] ceil_c_reg, floor_c_reg;
    logic        cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_w_reg <= 11'd64; tex_h_reg <= 11'd64;
            ceil_c_reg <= '0; floor_c_reg <= '0;
        end
        else if (cfg_wr && paddr[1:0] == 2'b00)
        begin
            unique case (paddr[3:2])
                REG_TEX_W:   tex_w_reg   <= pwdata[10:0];
                REG_TEX_H:   tex_h_reg   <= pwdata[10:0];
                REG_CEIL_C:  ceil_c_reg  <= pwdata[23:0];
                REG_FLOOR_C: floor_c_reg <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_TEX_W:   prdata = {21'd0, tex_w_reg};
            REG_TEX_H:   prdata = {21'd0, tex_h_reg};
            REG_CEIL_C:  prdata = {8'd0, ceil_c_reg};
            REG_FLOOR_C: prdata = {8'd0, floor_c_reg};
            default:     prdata = '0;
        endcase
    end

    function automatic logic [10:0] eff_dim(input logic [10:0] d);
        if (d == 11'd0)
            return 11'd1;
        if (32'(d) > MAX_TEX_DIM)
            return 11'(MAX_TEX_DIM);
        return d;
    endfunction

    // held column state
    logic [1:0]  sel_tex_reg;
    logic [9:0]  tcol_reg, top_reg, bot_reg;
    logic [15:0] lh_reg;
    logic [11:0] hcol_reg;
    logic [10:0] sky_reg, ground_reg;

    // load datapath
    logic [10:0] w_eff;
    logic        mirror;
    logic [16:0] fsel;
    logic [27:0] tprod;
    logic [10:0] tcol;
    logic [14:0] half;
    logic [15:0] lh_fix;
    logic [16:0] gsum;
    always_comb
    begin
        w_eff  = eff_dim(tex_w_reg);
        mirror = (!i_side && !i_xp) || (i_side && i_yp);
        fsel   = mirror ? (17'h10000 - {1'b0, i_frac}) : {1'b0, i_frac};
        tprod  = fsel * w_eff;
        tcol   = tprod[26:16];
        if (tcol >= w_eff)
            tcol = w_eff - 11'd1;
        lh_fix = (i_lh == 16'd0) ? 16'd1 : i_lh;
        half   = i_lh[15:1];
        gsum   = {2'b0, half} + 17'(MID);
    end

    logic load_acc;
    assign load_acc = in_ch.valid && in_ch.ready && !i_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_tex_reg <= '0; tcol_reg <= '0; lh_reg <= 16'd1;
            top_reg <= '0; bot_reg <= '0; hcol_reg <= '0;
            sky_reg <= '0; ground_reg <= 11'(SCREEN_ROWS);
        end
        else if (load_acc)
        begin
            sel_tex_reg <= i_side ? (i_yp ? 2'd0 : 2'd1) : (i_xp ? 2'd2 : 2'd3);
            tcol_reg    <= tcol[9:0];
            lh_reg      <= lh_fix;
            top_reg     <= i_top;
            bot_reg     <= i_bot;
            hcol_reg    <= i_col;
            sky_reg     <= (32'(half) >= MID) ? 11'd0 : 11'(MID - 32'(half));
            ground_reg  <= (32'(gsum) > SCREEN_ROWS) ? 11'(SCREEN_ROWS) : gsum[10:0];
        end
    end

    // row classification (registered, so the multiply stands alone)
    state_t      state_reg, state_next;
    logic        row_acc;
    logic [9:0]  row_reg;
    logic [1:0]  kind_reg;
    logic [23:0] color_reg;
    logic [16:0] pos;
    logic        wall_hit, ty_zero_reg;
    logic [16:0] dnum_reg;
    logic [10:0] h_reg;
    assign row_acc = in_ch.valid && in_ch.ready && i_op;
    assign pos = {7'd0, i_row} + {1'b0, lh_reg[15:1]};
    assign wall_hit = (32'(i_row) < SCREEN_ROWS) && i_row >= top_reg && i_row <= bot_reg;

    always_ff @(posedge clk)
    begin
        if (row_acc)
        begin
            row_reg     <= i_row;
            h_reg       <= eff_dim(tex_h_reg);
            ty_zero_reg <= (32'(pos) <= MID);
            dnum_reg    <= pos - 17'(MID);
            priority if (32'(i_row) >= SCREEN_ROWS)
            begin
                kind_reg <= KIND_NONE; color_reg <= '0;
            end
            else if (wall_hit)
            begin
                kind_reg <= KIND_WALL; color_reg <= '0;
            end
            else if (11'(i_row) < sky_reg)
            begin
                kind_reg <= KIND_CEIL; color_reg <= ceil_c_reg;
            end
            else if (11'(i_row) >= ground_reg)
            begin
                kind_reg <= KIND_FLOOR; color_reg <= floor_c_reg;
            end
            else
            begin
                kind_reg <= KIND_NONE; color_reg <= '0;
            end
        end
    end

    // divider
    logic          div_start, div_done;
    logic [QW-1:0] quo;
    logic [27:0]   dprod;
    assign dprod = dnum_reg * h_reg;
    rctm_div_chain u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(dprod[QW-1:0]), .divisor(lh_reg), .done(div_done), .quotient(quo)
    );

    // output register
    logic        out_vld_reg, out_load;
    logic [9:0]  ty_reg, ty_calc;
    always_comb
    begin
        if (ty_zero_reg)
            ty_calc = '0;
        else if (quo >= QW'(h_reg))
            ty_calc = 10'(h_reg - 11'd1);
        else
            ty_calc = quo[9:0];
    end

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                if (row_acc)
                    state_next = ST_DIV;
            ST_DIV:
            begin
                if (kind_reg != KIND_WALL)
                begin
                    out_load = 1'b1; state_next = ST_OUT;
                end
                else
                begin
                    div_start = 1'b1; state_next = ST_OUT;
                end
            end
            ST_OUT:
                if (out_vld_reg && out_ch.ready)
                    state_next = ST_IDLE;
                else if (div_done)
                    out_load = 1'b1;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE; out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_vld_reg <= 1'b1;
            else if (out_ch.ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            ty_reg <= (kind_reg == KIND_WALL) ? ty_calc : 10'd0;
    end

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign out_ch.valid = out_vld_reg;
    logic is_wall;
    assign is_wall = (kind_reg == KIND_WALL);
    assign out_ch.data = {kind_reg, color_reg,
                          is_wall ? sel_tex_reg : 2'd0,
                          is_wall ? tcol_reg : 10'd0,
                          ty_reg, hcol_reg, row_reg};

    // checks
    a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> state_reg == ST_OUT) else $error("result outside ST_OUT");
    a_no_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !in_ch.ready) else $error("accept while busy");
    a_color_wall: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && is_wall |-> color_reg == '0) else $error("wall with color");
endmodule
`default_nettype wire

FILE: verif/raycast_column_texel_mapper_core_tb.sv
// Self-checking testbench for raycast_column_texel_mapper_core: column loads and
// row words in, texel/colour words out, APB register setup between phases.
// Depends on rctm_pkg, rctm_if and the core RTL.
`default_nettype none
module raycast_column_texel_mapper_core_tb
    import rctm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS    = 1024;
    localparam int MAXDIM  = 1024;
    localparam int LIMIT   = 1500000;
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_ROW  = 1'b1;

    typedef struct packed {
        logic        op;
        logic        side;
        logic        dir_x_positive;
        logic        dir_y_positive;
        logic [15:0] wall_frac;
        logic [15:0] proj_height;
        logic [9:0]  wall_top;
        logic [9:0]  wall_bottom;
        logic [11:0] column;
        logic [9:0]  row;
    } ray_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] color;
        logic [1:0]  tex_id;
        logic [9:0]  tex_x;
        logic [9:0]  tex_y;
        logic [11:0] out_column;
        logic [9:0]  out_row;
    } pixel_word_t;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rctm_if #(.W($bits(ray_word_t)))   in_ch ();
    rctm_if #(.W($bits(pixel_word_t))) out_ch ();

    raycast_column_texel_mapper_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow registers and held column state
    logic [10:0] cfg_tex_w, cfg_tex_h;
    logic [23:0] cfg_ceil, cfg_floor;
    logic [1:0]  hold_tex;
    logic [9:0]  hold_tx;
    logic [15:0] hold_lh;
    logic [9:0]  hold_top, hold_bot;
    logic [11:0] hold_col;
    logic [10:0] hold_sky_end, hold_ground;

    ray_word_t   pending_rays[$];
    pixel_word_t expected_pixels[$];
    int          idle_mode;
    logic        in_taken;
    int          errors;
    int          cycles;
    int          n_rays, n_pixels, n_wall, n_ceil, n_floor, n_none;

    // clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [10:0] clamp_dim(logic [10:0] d);
        if (d == 0)
            return 11'd1;
        if (d > MAXDIM)
            return 11'(MAXDIM);
        return d;
    endfunction

    // column load updates held state; row word queues expected pixel
    task automatic shade_ray(input ray_word_t r);
        pixel_word_t p;
        logic [31:0] w, h, lh, half, t, pos;
        logic [63:0] q;
        logic        mirror;
        if (r.op == OP_LOAD)
        begin
            w  = 32'(clamp_dim(cfg_tex_w));
            lh = (r.proj_height == 0) ? 32'd1 : 32'(r.proj_height);
            if (r.side)
                hold_tex = r.dir_y_positive ? 2'd0 : 2'd1;
            else
                hold_tex = r.dir_x_positive ? 2'd2 : 2'd3;
            mirror = (!r.side && !r.dir_x_positive) || (r.side && r.dir_y_positive);
            if (mirror)
            begin
                t = ((32'd65536 - 32'(r.wall_frac)) * w) >> 16;
                if (t >= w)
                    t = w - 1;
            end
            else
                t = (32'(r.wall_frac) * w) >> 16;
            hold_tx  = t[9:0];
            hold_lh  = lh[15:0];
            hold_top = r.wall_top;
            hold_bot = r.wall_bottom;
            hold_col = r.column;
            half = lh / 2;
            hold_sky_end = (half >= ROWS / 2) ? 11'd0 : 11'(ROWS / 2 - half);
            hold_ground  = (half + ROWS / 2 > ROWS) ? 11'(ROWS) : 11'(half + ROWS / 2);
            return;
        end
        p = '0;
        p.kind       = KIND_NONE;
        p.out_column = hold_col;
        p.out_row    = r.row;
        if (r.row < ROWS)
        begin
            if (r.row >= hold_top && r.row <= hold_bot)
            begin
                h   = 32'(clamp_dim(cfg_tex_h));
                lh  = (hold_lh == 0) ? 32'd1 : 32'(hold_lh);
                pos = 32'(r.row) + lh / 2;
                p.kind   = KIND_WALL;
                p.tex_id = hold_tex;
                p.tex_x  = hold_tx;
                if (pos > ROWS / 2)
                begin
                    q = (64'(pos - ROWS / 2) * h) / lh;
                    p.tex_y = (q >= h) ? 10'(h - 1) : q[9:0];
                end
                n_wall++;
            end
            else if (r.row < hold_sky_end)
            begin
                p.kind  = KIND_CEIL;
                p.color = cfg_ceil;
                n_ceil++;
            end
            else if (r.row >= hold_ground)
            begin
                p.kind  = KIND_FLOOR;
                p.color = cfg_floor;
                n_floor++;
            end
            else
                n_none++;
        end
        expected_pixels.push_back(p);
    endtask

    // sender: one word held until taken, random gaps per idle mode
    always @(negedge clk)
    begin
        logic gap;
        gap = ((idle_mode == 1) && ($urandom_range(0, 99) < 72))
           || ((idle_mode == 3) && ($urandom_range(0, 99) < 28));
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
        end
        else if (!in_ch.valid || in_taken)
        begin
            if (pending_rays.size() > 0 && !gap)
            begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= pending_rays.pop_front();
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        if (idle_mode == 2)
            out_ch.ready <= ($urandom_range(0, 99) >= 72);
        else if (idle_mode == 3)
            out_ch.ready <= ($urandom_range(0, 99) >= 28);
        else
            out_ch.ready <= 1'b1;
    end

    // monitor: predict on accepted input, compare accepted output
    always @(posedge clk)
    begin
        pixel_word_t got, exp_p;
        cycles++;
        in_taken <= in_ch.valid && in_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            shade_ray(ray_word_t'(in_ch.data));
            n_rays++;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = pixel_word_t'(out_ch.data);
            n_pixels++;
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected pixel word %h", got);
                errors++;
            end
            else
            begin
                exp_p = expected_pixels.pop_front();
                if (got.kind != exp_p.kind)
                begin
                    $error("kind exp %0d got %0d", exp_p.kind, got.kind);
                    errors++;
                end
                if (got.color != exp_p.color)
                begin
                    $error("color exp %h got %h", exp_p.color, got.color);
                    errors++;
                end
                if (got.tex_id != exp_p.tex_id)
                begin
                    $error("tex_id exp %0d got %0d", exp_p.tex_id, got.tex_id);
                    errors++;
                end
                if (got.tex_x != exp_p.tex_x)
                begin
                    $error("tex_x exp %0d got %0d", exp_p.tex_x, got.tex_x);
                    errors++;
                end
                if (got.tex_y != exp_p.tex_y)
                begin
                    $error("tex_y exp %0d got %0d", exp_p.tex_y, got.tex_y);
                    errors++;
                end
                if (got.out_column != exp_p.out_column)
                begin
                    $error("out_column exp %0d got %0d", exp_p.out_column, got.out_column);
                    errors++;
                end
                if (got.out_row != exp_p.out_row)
                begin
                    $error("out_row exp %0d got %0d", exp_p.out_row, got.out_row);
                    errors++;
                end
            end
        end
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TEX_W:   cfg_tex_w = val[10:0];
            REG_TEX_H:   cfg_tex_h = val[10:0];
            REG_CEIL_C:  cfg_ceil  = val[23:0];
            default:     cfg_floor = val[23:0];
        endcase
    endtask

    task automatic set_regs(input logic [31:0] w, h, c, f);
        apb_write(REG_TEX_W, w);
        apb_write(REG_TEX_H, h);
        apb_write(REG_CEIL_C, c);
        apb_write(REG_FLOOR_C, f);
    endtask

    task automatic push_load(input logic side, xp, yp, input logic [15:0] frac, lh,
                             input logic [9:0] top, bot, input logic [11:0] col);
        ray_word_t r;
        r = '0;
        r.op = OP_LOAD;
        r.side = side;
        r.dir_x_positive = xp;
        r.dir_y_positive = yp;
        r.wall_frac = frac;
        r.proj_height = lh;
        r.wall_top = top;
        r.wall_bottom = bot;
        r.column = col;
        r.row = 10'($urandom);
        pending_rays.push_back(r);
    endtask

    task automatic push_row(input logic [9:0] row);
        ray_word_t   r;
        logic [95:0] noise;
        noise = {$urandom, $urandom, $urandom};
        r = noise[$bits(ray_word_t)-1:0];
        r.op  = OP_ROW;
        r.row = row;
        pending_rays.push_back(r);
    endtask

    // wait for every queued word and result, then let a load settle
    task automatic drain();
        wait (pending_rays.size() == 0 && !in_ch.valid && expected_pixels.size() == 0);
        repeat (40) @(posedge clk);
    endtask

    // one random column: a load then rows biased toward span and bounds
    task automatic random_column(input int nrows);
        logic [15:0] lh;
        logic [9:0]  top, bot, tmp;
        case ($urandom_range(0, 4))
            0:       lh = 16'($urandom_range(0, 8));
            1:       lh = 16'($urandom);
            2:       lh = 16'($urandom_range(1000, 2100));
            default: lh = 16'($urandom_range(1, 1023));
        endcase
        top = 10'($urandom);
        bot = 10'($urandom);
        if (top > bot && $urandom_range(0, 9) != 0)
        begin
            tmp = top;
            top = bot;
            bot = tmp;
        end
        push_load(1'($urandom), 1'($urandom), 1'($urandom), 16'($urandom), lh, top, bot,
                  12'($urandom));
        for (int i = 0; i < nrows; i++)
        begin
            if ($urandom_range(0, 2) == 0 && top <= bot)
                push_row(10'($urandom_range(top, bot)));
            else
                push_row(10'($urandom));
        end
    endtask

    initial
    begin
        int budget;
        int qlen;
        errors = 0; cycles = 0; n_rays = 0; n_pixels = 0;
        n_wall = 0; n_ceil = 0; n_floor = 0; n_none = 0;
        idle_mode = 0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cfg_tex_w = 11'd64; cfg_tex_h = 11'd64; cfg_ceil = '0; cfg_floor = '0;
        hold_tex = '0; hold_tx = '0; hold_lh = 16'd1; hold_top = '0; hold_bot = '0;
        hold_col = '0; hold_sky_end = '0; hold_ground = 11'(ROWS);
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset state rows, then extremes of fields and registers
        push_row(10'd0);
        push_row(10'd1023);
        drain();
        set_regs(32'd64, 32'd64, 32'h00FFFFFF, 32'h00A5A5A5);
        push_load(1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 10'd0, 10'd1023, 12'd0);
        push_row(10'd0);
        push_row(10'd1023);
        push_load(1'b0, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 10'd0, 10'd1023, 12'hFFF);
        push_row(10'd512);
        push_row(10'd1023);
        push_load(1'b1, 1'b0, 1'b1, 16'd1, 16'd100, 10'd480, 10'd540, 12'd77);
        push_row(10'd0);
        push_row(10'd470);
        push_row(10'd480);
        push_row(10'd540);
        push_row(10'd560);
        push_row(10'd1000);
        push_load(1'b1, 1'b1, 1'b0, 16'h8000, 16'd200, 10'd600, 10'd400, 12'd5);
        push_row(10'd500);
        push_row(10'd100);
        push_row(10'd900);
        push_load(1'b0, 1'b0, 1'b1, 16'd0, 16'd1, 10'd0, 10'd0, 12'd9);
        push_row(10'd0);
        drain();
        set_regs(32'd0, 32'd2047, 32'h0, 32'h00FFFFFF);
        push_load(1'b0, 1'b0, 1'b0, 16'd0, 16'd50, 10'd500, 10'd530, 12'd1);
        push_row(10'd520);
        push_load(1'b1, 1'b1, 1'b1, 16'h0001, 16'd3000, 10'd0, 10'd1023, 12'd2);
        push_row(10'd1023);
        drain();

        // random phases over register settings and idle modes
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: set_regs(32'd1, 32'd1, 32'($urandom), 32'($urandom));
                1: set_regs(32'd1024, 32'd1024, 32'($urandom), 32'($urandom));
                2: set_regs(32'd2047, 32'd0, 32'($urandom), 32'($urandom));
                3: set_regs(32'd1025, 32'd1023, 32'h0, 32'h0);
                default: set_regs($urandom_range(0, 2047), $urandom_range(0, 2047),
                                  32'($urandom), 32'($urandom));
            endcase
            idle_mode = ph % 4;
            budget = 0;
            while (budget < 125)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    push_row(10'($urandom));
                    budget++;
                end
                else
                begin
                    qlen = pending_rays.size();
                    random_column($urandom_range(1, 12));
                    budget = budget + pending_rays.size() - qlen;
                end
                if ($urandom_range(0, 3) == 0)
                    wait (pending_rays.size() == 0);
            end
            drain();
        end
        idle_mode = 0;
        repeat (40) @(posedge clk);

        $display("covered %0d input words, %0d pixel words", n_rays, n_pixels);
        $display("rows seen: %0d wall, %0d ceiling, %0d floor, %0d none",
                 n_wall, n_ceil, n_floor, n_none);
        if (errors == 0 && expected_pixels.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
